[hdl/updec_pkg.sv]
package updec_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // What is held between bytes: nothing, a '%', or a '%' and one hex digit.
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PCT,
    PEND_DIGIT
  } pend_e;

  localparam int unsigned MaxItems = 3;

  // Result items caused by one input byte; a marker is a bare end item.
  typedef struct packed {
    logic [1:0]                count;
    logic [MaxItems-1:0][7:0]  bytes;
    logic                      marker;
    logic                      last;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_FORM_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAFE_MODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DROP_CTRL   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REFUSE_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REFUSE_HIGH = 3'd4;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[hdl/updec_front.sv]
module updec_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [updec_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [updec_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  updec_pkg::in_item_t                 in_data_i,
  input  logic                                full_i,
  output logic                                push_o,
  output updec_pkg::bundle_t                  bundle_o
);

  logic                                form_q, safe_q, drop_q;
  logic [updec_pkg::CfgDataW-1:0]      mask_lo_q, mask_hi_q;
  updec_pkg::pend_e                    pend_q, pend_d;
  logic [7:0]                          digit_q, digit_d;
  logic                                accept;
  updec_pkg::hex_t                     hx, hd;
  logic [7:0]                          dec;
  logic [2*updec_pkg::CfgDataW-1:0]    mask;
  logic                                refused, dropped, do_plain;
  updec_pkg::bundle_t                  bd;

  function automatic updec_pkg::bundle_t add_item(updec_pkg::bundle_t b, logic [7:0] c);
    updec_pkg::bundle_t r;
    r = b;
    if (r.count != 2'(updec_pkg::MaxItems)) begin
      r.bytes[r.count] = c;
      r.count          = r.count + 2'd1;
    end
    return r;
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q    <= 1'b0;
      safe_q    <= 1'b0;
      drop_q    <= 1'b0;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        updec_pkg::CFG_FORM_MODE:   form_q    <= cfg_data_i[0];
        updec_pkg::CFG_SAFE_MODE:   safe_q    <= cfg_data_i[0];
        updec_pkg::CFG_DROP_CTRL:   drop_q    <= cfg_data_i[0];
        updec_pkg::CFG_REFUSE_LOW:  mask_lo_q <= cfg_data_i;
        updec_pkg::CFG_REFUSE_HIGH: mask_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hx      = updec_pkg::hex_decode(in_data_i.in_byte);
    hd      = updec_pkg::hex_decode(digit_q);
    dec     = {hd.val, hx.val};
    mask    = {mask_hi_q, mask_lo_q};
    refused = safe_q && !dec[7] && mask[dec[6:0]];
    dropped = drop_q && (dec == updec_pkg::CH_NUL || dec == updec_pkg::CH_LF ||
                         dec == updec_pkg::CH_CR);
    bd       = '0;
    pend_d   = pend_q;
    digit_d  = digit_q;
    do_plain = 1'b0;

    case (pend_q)
      updec_pkg::PEND_PCT: begin
        if (hx.ok) begin
          pend_d  = updec_pkg::PEND_DIGIT;
          digit_d = in_data_i.in_byte;
        end else begin
          pend_d   = updec_pkg::PEND_NONE;
          bd       = add_item(bd, updec_pkg::CH_PCT);
          do_plain = 1'b1;
        end
      end
      updec_pkg::PEND_DIGIT: begin
        pend_d = updec_pkg::PEND_NONE;
        if (hx.ok) begin
          if (refused) begin
            bd = add_item(bd, updec_pkg::CH_PCT);
            bd = add_item(bd, digit_q);
            bd = add_item(bd, in_data_i.in_byte);
          end else if (!dropped) begin
            bd = add_item(bd, dec);
          end
        end else begin
          // malformed: literal '%' and digit, then rescan this byte
          bd       = add_item(bd, updec_pkg::CH_PCT);
          bd       = add_item(bd, digit_q);
          do_plain = 1'b1;
        end
      end
      default: begin
        pend_d   = updec_pkg::PEND_NONE;
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (form_q && in_data_i.in_byte == updec_pkg::CH_PLUS) begin
        bd = add_item(bd, updec_pkg::CH_SPACE);
      end else if (in_data_i.in_byte == updec_pkg::CH_PCT) begin
        pend_d = updec_pkg::PEND_PCT;
      end else begin
        bd = add_item(bd, in_data_i.in_byte);
      end
    end

    if (in_data_i.in_last) begin
      if (pend_d == updec_pkg::PEND_PCT) begin
        bd = add_item(bd, updec_pkg::CH_PCT);
      end else if (pend_d == updec_pkg::PEND_DIGIT) begin
        bd = add_item(bd, updec_pkg::CH_PCT);
        bd = add_item(bd, digit_d);
      end
      pend_d  = updec_pkg::PEND_NONE;
      digit_d = 8'd0;
      bd.last = 1'b1;
      if (bd.count == 2'd0) begin
        bd.count  = 2'd1;
        bd.marker = 1'b1;
      end
    end
  end

  assign push_o   = accept && (bd.count != 2'd0);
  assign bundle_o = bd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= updec_pkg::PEND_NONE;
      digit_q <= 8'd0;
    end else if (accept) begin
      pend_q  <= pend_d;
      digit_q <= digit_d;
    end
  end

endmodule

[hdl/updec_queue.sv]
module updec_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  updec_pkg::bundle_t data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output updec_pkg::bundle_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  updec_pkg::bundle_t  mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= bump(wr_q);
      end
      if (do_pop) begin
        rd_q <= bump(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/updec_back.sv]
module updec_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  updec_pkg::bundle_t   head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output updec_pkg::out_item_t out_data_o
);

  logic                 oval_q;
  updec_pkg::out_item_t opay_q;
  logic [1:0]           idx_q;
  logic                 advance, take, at_end;

  assign advance = !oval_q || !out_stall_i;
  assign take    = advance && head_valid_i;
  assign at_end  = (idx_q == head_i.count - 2'd1);
  assign pop_o   = take && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (advance) begin
      oval_q <= head_valid_i;
      if (head_valid_i) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      opay_q.out_byte  <= head_i.marker ? 8'd0 : head_i.bytes[idx_q];
      opay_q.out_valid <= !head_i.marker;
      opay_q.out_last  <= head_i.last && at_end;
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = opay_q;

endmodule

[hdl/url_percent_decoder_core.sv]
// Channel | Valid       | Stall       | Beat
// in      | in_valid_i  | in_stall_o  | in_data_i  (in_byte, in_last)
// out     | out_valid_o | out_stall_i | out_data_o (out_byte, out_valid, out_last)
// cfg     | cfg_we_i    | -           | cfg_idx_i, cfg_data_i
//
// Unstalled, one input byte per cycle while each yields at most one output beat.
// A byte that yields k beats (a refused or broken escape, up to 3) holds the
// output register until all k are out; the bundle queue (QueueDepth entries)
// lets the front keep taking bytes meanwhile and stalls it only when full.
// Each bundle is registered in the queue and then in the output register.
// Reset clears config, pending escape state, queue and output register.
module url_percent_decoder_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [updec_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [updec_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  updec_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output updec_pkg::out_item_t            out_data_o
);

  logic               full, push, pop, head_valid;
  updec_pkg::bundle_t bundle, head;

  updec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  updec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_i       (bundle),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  updec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[hdl/updec_checker.sv]
module updec_sva (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input updec_pkg::out_item_t out_data_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // a bare end marker only ever closes a string
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |-> out_data_o.out_last)
    else $error("end marker without last");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |-> out_data_o.out_byte == 8'd0)
    else $error("end marker carries data");

endmodule

bind url_percent_decoder_core updec_sva u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/sv/updec_checker.sv]
`timescale 1ns / 100ps

module updec_checker
  import updec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  logic        form_q;
  logic        safe_q;
  logic        drop_q;
  logic [63:0] refuse_lo_q;
  logic [63:0] refuse_hi_q;
  pend_e       held_q;
  logic [7:0]  held_digit_q;

  out_item_t   expected_beats[$];
  out_item_t   step_beats[$];
  int          errors;

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // Bytes at or above 128 are never refused.
  function automatic logic is_refused(logic [7:0] c);
    if (!safe_q || c[7]) return 1'b0;
    return c[6] ? refuse_hi_q[c[5:0]] : refuse_lo_q[c[5:0]];
  endfunction

  function automatic void emit(logic [7:0] b);
    if (step_beats.size() < MaxItems)
      step_beats.push_back('{out_byte: b, out_valid: 1'b1, out_last: 1'b0});
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (form_q && b == CH_PLUS) begin
      emit(CH_SPACE);
    end else if (b == CH_PCT) begin
      held_q = PEND_PCT;
    end else begin
      emit(b);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    int         lo;
    int         hi;
    logic [7:0] c;
    step_beats.delete();
    lo = hex_nibble(b);
    case (held_q)
      PEND_PCT: begin
        if (lo >= 0) begin
          held_digit_q = b;
          held_q       = PEND_DIGIT;
        end else begin
          held_q = PEND_NONE;
          emit(CH_PCT);
          plain_byte(b);
        end
      end
      PEND_DIGIT: begin
        hi     = hex_nibble(held_digit_q);
        held_q = PEND_NONE;
        if (lo >= 0 && hi >= 0) begin
          c = {hi[3:0], lo[3:0]};
          if (is_refused(c)) begin
            emit(CH_PCT);
            emit(held_digit_q);
            emit(b);
          end else if (!(drop_q && (c == CH_NUL || c == CH_LF || c == CH_CR))) begin
            emit(c);
          end
        end else begin
          emit(CH_PCT);
          emit(held_digit_q);
          plain_byte(b);
        end
      end
      default: begin
        held_q = PEND_NONE;
        plain_byte(b);
      end
    endcase

    if (last) begin
      if (held_q == PEND_PCT) begin
        emit(CH_PCT);
      end else if (held_q == PEND_DIGIT) begin
        emit(CH_PCT);
        emit(held_digit_q);
      end
      held_q       = PEND_NONE;
      held_digit_q = '0;
      // nothing left to carry the end flag: bare end marker
      if (step_beats.size() == 0) begin
        step_beats.push_back('{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1});
      end else begin
        step_beats[step_beats.size() - 1].out_last = 1'b1;
      end
    end

    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected output beat byte=%h valid=%b last=%b",
                                got.out_byte, got.out_valid, got.out_last));
    end else begin
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
      if (got.out_valid !== want.out_valid)
        report_mismatch($sformatf("out_valid %b, expected %b", got.out_valid, want.out_valid));
      if (got.out_last !== want.out_last)
        report_mismatch($sformatf("out_last %b, expected %b", got.out_last, want.out_last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q       = 1'b0;
      safe_q       = 1'b0;
      drop_q       = 1'b0;
      refuse_lo_q  = '0;
      refuse_hi_q  = '0;
      held_q       = PEND_NONE;
      held_digit_q = '0;
      expected_beats.delete();
      errors       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FORM_MODE:   form_q      = cfg_data_i[0];
          CFG_SAFE_MODE:   safe_q      = cfg_data_i[0];
          CFG_DROP_CTRL:   drop_q      = cfg_data_i[0];
          CFG_REFUSE_LOW:  refuse_lo_q = cfg_data_i;
          CFG_REFUSE_HIGH: refuse_hi_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_beat(out_data_i);
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i.in_byte, in_data_i.in_last);
    end
    errors_o  <= errors;
    pending_o <= expected_beats.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import updec_pkg::*;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  int       errors;
  int       pending;
  bit       idle_en  = 1'b1;
  int       gap_odds = 2;
  in_item_t stream_q[$];

  url_percent_decoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  updec_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("url_percent_decoder_core test failed");
    $finish;
  end

  // receiver back-pressure
  initial begin
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  function automatic logic is_hex_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] v8;
    v8 = {4'h0, v};
    if (v < 10) return "0" + v8;
    return ($urandom_range(0, 1) ? "a" : "A") + v8 - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (is_hex_char(b)) b ^= 8'h80;
    return b;
  endfunction

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stream_q.push_back('{in_byte: b, in_last: 1'b0});
  endfunction

  function automatic void mark_end();
    stream_q[stream_q.size() - 1].in_last = 1'b1;
  endfunction

  function automatic void add_token();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // well-formed escape, now and then a control byte
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0:       b = CH_NUL;
          1:       b = CH_LF;
          default: b = CH_CR;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      push_byte(CH_PCT);
      push_byte(hex_char(b[7:4]));
      push_byte(hex_char(b[3:0]));
    end else if (pick < 55) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      push_byte(CH_PLUS);
    end else if (pick < 75) begin
      push_byte(CH_PCT);
      push_byte(non_hex_char());
    end else if (pick < 85) begin
      push_byte(CH_PCT);
      push_byte(hex_char(4'($urandom_range(0, 15))));
      push_byte(non_hex_char());
    end else if (pick < 90) begin
      push_byte(CH_PCT);
    end else begin
      // string ends inside an escape
      push_byte(CH_PCT);
      if ($urandom_range(0, 1)) push_byte(hex_char(4'($urandom_range(0, 15))));
      mark_end();
    end
    if ($urandom_range(0, 7) == 0) mark_end();
  endfunction

  task automatic send_beat(logic [7:0] b, logic last);
    if (idle_en && gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, in_last: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_str(string s, logic last_at_end);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], last_at_end && i == s.len() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_regs(logic form, logic safe, logic drop,
                              logic [63:0] refuse_lo, logic [63:0] refuse_hi);
    logic [CfgDataW-1:0] noise;
    cfg_we_i <= 1'b1;
    noise = {$urandom, $urandom};
    noise[0] = form;
    cfg_idx_i  <= CFG_FORM_MODE;
    cfg_data_i <= noise;
    @(posedge clk_i);
    noise = {$urandom, $urandom};
    noise[0] = safe;
    cfg_idx_i  <= CFG_SAFE_MODE;
    cfg_data_i <= noise;
    @(posedge clk_i);
    noise = {$urandom, $urandom};
    noise[0] = drop;
    cfg_idx_i  <= CFG_DROP_CTRL;
    cfg_data_i <= noise;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_REFUSE_LOW;
    cfg_data_i <= refuse_lo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_REFUSE_HIGH;
    cfg_data_i <= refuse_hi;
    @(posedge clk_i);
    // index past the register list, must be ignored
    cfg_idx_i  <= CFG_REFUSE_HIGH + CfgIdxW'($urandom_range(1, 3));
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: lowercase hex digit, broken escapes, flush of a held '%'
    send_beat(CH_NUL, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_str("%4a%z%4%41+%", 1'b1);
    drain();

    // refused escape, dropped CR/LF, high byte never refused, bare end marker
    program_regs(1'b1, 1'b1, 1'b1, ~64'h2401, '1);
    send_str("%41%0d+%FF%0A", 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        program_regs(1'b1, 1'b1, 1'b1, '1, '1);
      end else if (ph == 1) begin
        program_regs(1'b0, 1'b0, 1'b0, '0, '0);
      end else begin
        program_regs(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                     1'($urandom_range(0, 1)), pick_mask(), pick_mask());
      end
      idle_en  = (ph < 7);
      gap_odds = $urandom_range(0, 3);
      stream_q.delete();
      while (stream_q.size() < 60) add_token();
      foreach (stream_q[i]) send_beat(stream_q[i].in_byte, stream_q[i].in_last);
      drain();
    end

    if (errors == 0) begin
      $display("url_percent_decoder_core test passed");
    end else begin
      $display("url_percent_decoder_core test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/updec_pkg.sv
hdl/updec_front.sv
hdl/updec_queue.sv
hdl/updec_back.sv
hdl/url_percent_decoder_core.sv
hdl/updec_checker.sv
tb/sv/updec_checker.sv
tb/sv/tb.sv
